>>> hdl/getb_pkg.sv
// getb_pkg: shared types and constants for the graph edge table builder
// used by getb_cmp, getb_mem and graph_edge_table_builder_unit
// no dependencies
package getb_pkg;

    // default sizes, overridable on the top level
    localparam int NODE_DEPTH_DEF = 1024;
    localparam int MAX_SUCC_DEF   = 8;
    localparam int ID_BITS_DEF    = 40;

    // fixed result field widths
    localparam int STATUS_W   = 3;
    localparam int OUT_IDX_W  = 10;
    localparam int OUT_CNT_W  = 4;
    localparam int OUT_DATA_W = 16;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EDGE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED    = 3'd0,
        ST_ADDED     = 3'd1,
        ST_DUP       = 3'd2,
        ST_MISSING   = 3'd3,
        ST_LISTFULL  = 3'd4,
        ST_TABLEFULL = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PROBE,
        S_TEST,
        S_CNT_USE,
        S_SCAN,
        S_SCAN_TEST,
        S_APPEND,
        S_FINISH
    } state_t;

    typedef enum logic {
        CMP_NODE = 1'b0,
        CMP_LIST = 1'b1
    } cmp_sel_t;

    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

    typedef struct packed {
        logic node_we;
        logic cnt_we;
        logic list_we;
    } mem_we_t;

endpackage

>>> hdl/getb_cmp.sv
// getb_cmp: the shared id comparator used by the table search and the list scan
// depends on getb_pkg
module getb_cmp import getb_pkg::*; #(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  cmp_sel_t           sel,
    input  logic [ID_BITS-1:0] node_data,
    input  logic [ID_BITS-1:0] list_data,
    input  logic [ID_BITS-1:0] src_key,
    input  logic [ID_BITS-1:0] dst_key,
    output cmp_res_t           res
);

    logic [ID_BITS-1:0] a;
    logic [ID_BITS-1:0] b;

    always_comb begin
        unique case (sel)
            CMP_NODE: begin
                a = node_data;
                b = src_key;
            end
            CMP_LIST: begin
                a = list_data;
                b = dst_key;
            end
            default: begin
                a = node_data;
                b = src_key;
            end
        endcase
    end

    // lt means the stored id is below the key
    assign res.eq = (a == b);
    assign res.lt = (a < b);

endmodule

>>> hdl/getb_mem.sv
// getb_mem: node id table, successor counts and successor lists with registered reads
// depends on getb_pkg
module getb_mem import getb_pkg::*; #(
    parameter int NODE_DEPTH = NODE_DEPTH_DEF,
    parameter int MAX_SUCC   = MAX_SUCC_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    localparam int IDX_W     = $clog2(NODE_DEPTH),
    localparam int SUCC_W    = $clog2(MAX_SUCC),
    localparam int CNT_W     = $clog2(MAX_SUCC + 1),
    localparam int LIST_W    = IDX_W + SUCC_W
) (
    input  logic               aclk,
    input  mem_we_t            we,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [ID_BITS-1:0] node_wdata,
    input  logic [CNT_W-1:0]   cnt_wdata,
    input  logic [LIST_W-1:0]  list_waddr,
    input  logic [ID_BITS-1:0] list_wdata,
    input  logic [IDX_W-1:0]   node_raddr,
    input  logic [IDX_W-1:0]   cnt_raddr,
    input  logic [LIST_W-1:0]  list_raddr,
    output logic [ID_BITS-1:0] node_rdata,
    output logic [CNT_W-1:0]   cnt_rdata,
    output logic [ID_BITS-1:0] list_rdata
);

    localparam int LIST_DEPTH = NODE_DEPTH * (2 ** SUCC_W);

    logic [ID_BITS-1:0] node_mem [NODE_DEPTH];
    logic [CNT_W-1:0]   cnt_mem  [NODE_DEPTH];
    logic [ID_BITS-1:0] list_mem [LIST_DEPTH];

    always_ff @(posedge aclk) begin
        if (we.node_we) begin
            node_mem[wr_idx] <= node_wdata;
        end
        node_rdata <= node_mem[node_raddr];
    end

    always_ff @(posedge aclk) begin
        if (we.cnt_we) begin
            cnt_mem[wr_idx] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    // each node owns a row of power-of-two size
    always_ff @(posedge aclk) begin
        if (we.list_we) begin
            list_mem[list_waddr] <= list_wdata;
        end
        list_rdata <= list_mem[list_raddr];
    end

endmodule

>>> hdl/graph_edge_table_builder_unit.sv
// load beat: S_LOAD writes the table, S_FINISH registers the result; edge beat:
// search probes (at most log2(NODE_DEPTH)+1), a successor scan, S_APPEND, S_FINISH
// one beat is in flight at a time: the sequencer and its single comparator and
// memory read ports set the rate; s_axis_tready is high only while idle
// aresetn (synchronous) clears the node count, sequencer and output valid;
// memory contents are left as they are and read only after being written
module graph_edge_table_builder_unit import getb_pkg::*; #(
    parameter int NODE_DEPTH = NODE_DEPTH_DEF,
    parameter int MAX_SUCC   = MAX_SUCC_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    localparam int IN_DATA_W = ((3 * ID_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // node_id, source_id, dest_id (ID_BITS each), zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // source_index[9:0], successor_count[13:10], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]   m_axis_tuser
);

    localparam int IDX_W  = $clog2(NODE_DEPTH);
    localparam int TOT_W  = $clog2(NODE_DEPTH + 1);
    localparam int SUCC_W = $clog2(MAX_SUCC);
    localparam int CNT_W  = $clog2(MAX_SUCC + 1);
    localparam int LIST_W = IDX_W + SUCC_W;

    state_t state_reg, state_next;

    logic [ID_BITS-1:0] node_reg, node_next;
    logic [ID_BITS-1:0] src_reg, src_next;
    logic [ID_BITS-1:0] dst_reg, dst_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [TOT_W-1:0]   lo_reg, lo_next;
    logic [TOT_W-1:0]   hi_reg, hi_next;
    logic [TOT_W-1:0]   mid_reg, mid_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    status_t            res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic [CNT_W-1:0]   res_cnt_reg, res_cnt_next;

    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [OUT_IDX_W-1:0] m_idx_reg, m_idx_next;
    logic [OUT_CNT_W-1:0] m_cnt_reg, m_cnt_next;

    logic                     in_beat;
    logic                     out_free;
    logic [TOT_W-1:0]         mid;
    logic [IDX_W+OUT_IDX_W-1:0] idx_ext;
    logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;
    logic [CNT_W-1:0]         cnt_clamped;

    mem_we_t            mem_we;
    logic [IDX_W-1:0]   wr_idx;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [LIST_W-1:0]  list_waddr;
    logic [LIST_W-1:0]  list_raddr;
    logic [ID_BITS-1:0] node_rdata;
    logic [CNT_W-1:0]   cnt_rdata;
    logic [ID_BITS-1:0] list_rdata;
    cmp_sel_t           cmp_sel;
    cmp_res_t           cmp_res;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign mid           = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cnt_clamped   = (cnt_rdata > CNT_W'(MAX_SUCC)) ? CNT_W'(MAX_SUCC) : cnt_rdata;
    assign idx_ext       = {{OUT_IDX_W{1'b0}}, res_idx_reg};
    assign cnt_ext       = {{OUT_CNT_W{1'b0}}, res_cnt_reg};
    assign list_raddr    = {idx_reg, k_reg[SUCC_W-1:0]};
    assign list_waddr    = {idx_reg, cnt_reg[SUCC_W-1:0]};

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_IDX_W - OUT_CNT_W){1'b0}}, m_cnt_reg, m_idx_reg};

    getb_mem #(
        .NODE_DEPTH (NODE_DEPTH),
        .MAX_SUCC   (MAX_SUCC),
        .ID_BITS    (ID_BITS)
    ) u_mem (
        .aclk       (aclk),
        .we         (mem_we),
        .wr_idx     (wr_idx),
        .node_wdata (node_reg),
        .cnt_wdata  (cnt_wdata),
        .list_waddr (list_waddr),
        .list_wdata (dst_reg),
        .node_raddr (mid[IDX_W-1:0]),
        .cnt_raddr  (mid_reg[IDX_W-1:0]),
        .list_raddr (list_raddr),
        .node_rdata (node_rdata),
        .cnt_rdata  (cnt_rdata),
        .list_rdata (list_rdata)
    );

    getb_cmp #(
        .ID_BITS (ID_BITS)
    ) u_cmp (
        .sel       (cmp_sel),
        .node_data (node_rdata),
        .list_data (list_rdata),
        .src_key   (src_reg),
        .dst_key   (dst_reg),
        .res       (cmp_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    state_next = (cmd_t'(s_axis_tuser[0]) == CMD_LOAD) ? S_LOAD : S_PROBE;
                end
            end
            S_LOAD: begin
                state_next = S_FINISH;
            end
            S_PROBE: begin
                state_next = (lo_reg < hi_reg) ? S_TEST : S_FINISH;
            end
            S_TEST: begin
                state_next = cmp_res.eq ? S_CNT_USE : S_PROBE;
            end
            S_CNT_USE: begin
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (k_reg != cnt_reg) begin
                    state_next = S_SCAN_TEST;
                end else if (cnt_reg >= CNT_W'(MAX_SUCC)) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_APPEND;
                end
            end
            S_SCAN_TEST: begin
                state_next = cmp_res.eq ? S_FINISH : S_SCAN;
            end
            S_APPEND: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        node_next       = node_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        total_next      = total_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_cnt_next    = res_cnt_reg;
        mem_we          = '0;
        wr_idx          = idx_reg;
        cnt_wdata       = '0;
        cmp_sel         = CMP_NODE;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_status_next   = m_status_reg;
        m_idx_next      = m_idx_reg;
        m_cnt_next      = m_cnt_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    node_next = s_axis_tdata[ID_BITS-1:0];
                    src_next  = s_axis_tdata[2*ID_BITS-1:ID_BITS];
                    dst_next  = s_axis_tdata[3*ID_BITS-1:2*ID_BITS];
                    lo_next   = '0;
                    hi_next   = total_reg;
                end
            end
            S_LOAD: begin
                if (total_reg == TOT_W'(NODE_DEPTH)) begin
                    res_status_next = ST_TABLEFULL;
                    res_idx_next    = '0;
                    res_cnt_next    = '0;
                end else begin
                    mem_we.node_we  = 1'b1;
                    mem_we.cnt_we   = 1'b1;
                    wr_idx          = total_reg[IDX_W-1:0];
                    total_next      = total_reg + 1'b1;
                    res_status_next = ST_LOADED;
                    res_idx_next    = total_reg[IDX_W-1:0];
                    res_cnt_next    = '0;
                end
            end
            S_PROBE: begin
                mid_next = mid;
                if (lo_reg >= hi_reg) begin
                    res_status_next = ST_MISSING;
                    res_idx_next    = '0;
                    res_cnt_next    = '0;
                end
            end
            S_TEST: begin
                cmp_sel = CMP_NODE;
                if (cmp_res.eq) begin
                    idx_next = mid_reg[IDX_W-1:0];
                end else if (cmp_res.lt) begin
                    lo_next = mid_reg + 1'b1;
                end else begin
                    hi_next = mid_reg;
                end
            end
            S_CNT_USE: begin
                // count read at the found index lands here
                cnt_next = cnt_clamped;
                k_next   = '0;
            end
            S_SCAN: begin
                if (k_reg == cnt_reg) begin
                    res_status_next = ST_LISTFULL;
                    res_idx_next    = idx_reg;
                    res_cnt_next    = cnt_reg;
                end
            end
            S_SCAN_TEST: begin
                cmp_sel = CMP_LIST;
                if (cmp_res.eq) begin
                    res_status_next = ST_DUP;
                    res_idx_next    = idx_reg;
                    res_cnt_next    = cnt_reg;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_APPEND: begin
                mem_we.list_we  = 1'b1;
                mem_we.cnt_we   = 1'b1;
                wr_idx          = idx_reg;
                cnt_wdata       = cnt_reg + 1'b1;
                res_status_next = ST_ADDED;
                res_idx_next    = idx_reg;
                res_cnt_next    = cnt_reg + 1'b1;
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_idx_next    = idx_ext[OUT_IDX_W-1:0];
                    m_cnt_next    = cnt_ext[OUT_CNT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg       <= node_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_cnt_reg    <= res_cnt_next;
        m_status_reg   <= m_status_next;
        m_idx_reg      <= m_idx_next;
        m_cnt_reg      <= m_cnt_next;
    end

endmodule
